>>> rtl/lenient_utf8_decoder_assert.svh
// Assertion macros for the lenient UTF-8 decoder checker.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef LENIENT_UTF8_DECODER_ASSERT_SVH
`define LENIENT_UTF8_DECODER_ASSERT_SVH

// Checked on every rising clock edge outside of reset.
`define LUTF8_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LUTF8_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lutf8_pkg.sv
// Package for the lenient UTF-8 decoder: transaction types, decoder state and constants.
// No dependencies.
`timescale 1ns / 1ps

package lutf8_pkg;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned LenWidth = 3;

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Mask2      = 8'hE0;
  localparam logic [7:0] Lead2      = 8'hC0;
  localparam logic [7:0] Mask3      = 8'hF0;
  localparam logic [7:0] Lead3      = 8'hE0;
  localparam logic [7:0] Mask4      = 8'hF8;
  localparam logic [7:0] Lead4      = 8'hF0;
  localparam logic [7:0] Bits2      = 8'h1F;
  localparam logic [7:0] Bits3      = 8'h0F;
  localparam logic [7:0] Bits4      = 8'h07;
  localparam logic [7:0] ContBits   = 8'h3F;

  localparam logic [LenWidth-1:0] Len1 = 3'd1;
  localparam logic [LenWidth-1:0] Len2 = 3'd2;
  localparam logic [LenWidth-1:0] Len3 = 3'd3;
  localparam logic [LenWidth-1:0] Len4 = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic [LenWidth-1:0] sequence_length;
    logic                last_point;
    logic                truncated;
  } point_item_t;

  typedef struct packed {
    logic [1:0]          bytes_pending;
    logic [CpWidth-1:0]  partial_value;
    logic [LenWidth-1:0] pending_length;
  } dec_state_t;

  typedef struct packed {
    logic        emit;
    point_item_t point;
  } step_result_t;

  localparam dec_state_t IdleState = '{
    bytes_pending:  2'd0,
    partial_value:  '0,
    pending_length: Len1
  };

endpackage

>>> rtl/lutf8_step.sv
// Combinational decode step: applies one byte to the decoder state.
// Depends on lutf8_pkg.
`timescale 1ns / 1ps

module lutf8_step (
  input  lutf8_pkg::dec_state_t   cur_state,
  input  lutf8_pkg::byte_item_t   item,
  output lutf8_pkg::dec_state_t   state_next,
  output lutf8_pkg::step_result_t result
);
  import lutf8_pkg::*;

  logic                lead_ok;
  logic [LenWidth-1:0] lead_len;
  logic [7:0]          lead_bits;
  logic [1:0]          acc_pending;
  logic [CpWidth-1:0]  acc_value;
  logic [LenWidth-1:0] acc_length;
  logic [CpWidth-1:0]  filled_value;

  always_comb begin
    lead_ok   = 1'b1;
    lead_len  = Len2;
    lead_bits = item.data_byte & Bits2;
    priority if ((item.data_byte & Mask2) == Lead2) begin
      lead_len  = Len2;
      lead_bits = item.data_byte & Bits2;
    end else if ((item.data_byte & Mask3) == Lead3) begin
      lead_len  = Len3;
      lead_bits = item.data_byte & Bits3;
    end else if ((item.data_byte & Mask4) == Lead4) begin
      lead_len  = Len4;
      lead_bits = item.data_byte & Bits4;
    end else begin
      lead_ok = 1'b0;
    end
  end

  always_comb begin
    if (cur_state.bytes_pending == 2'd0) begin
      acc_value   = {{(CpWidth-8){1'b0}}, lead_bits};
      acc_pending = lead_len[1:0] - 2'd1;
      acc_length  = lead_len;
    end else begin
      acc_value   = {cur_state.partial_value[CpWidth-7:0], item.data_byte[5:0]};
      acc_pending = cur_state.bytes_pending - 2'd1;
      acc_length  = cur_state.pending_length;
    end
  end

  // Missing continuation bytes contribute six zero bits each.
  always_comb begin
    unique case (acc_pending)
      2'd1:    filled_value = {acc_value[CpWidth-7:0], 6'd0};
      2'd2:    filled_value = {acc_value[CpWidth-13:0], 12'd0};
      2'd3:    filled_value = {acc_value[CpWidth-19:0], 18'd0};
      default: filled_value = acc_value;
    endcase
  end

  always_comb begin
    state_next = cur_state;
    result     = '0;
    if (cur_state.bytes_pending == 2'd0 && (item.data_byte < AsciiLimit || !lead_ok)) begin
      result.emit                  = 1'b1;
      result.point.code_point      = {{(CpWidth-8){1'b0}}, item.data_byte};
      result.point.sequence_length = Len1;
      result.point.last_point      = item.last_byte;
      result.point.truncated       = 1'b0;
      state_next                   = IdleState;
    end else if (acc_pending == 2'd0) begin
      result.emit                  = 1'b1;
      result.point.code_point      = acc_value;
      result.point.sequence_length = acc_length;
      result.point.last_point      = item.last_byte;
      result.point.truncated       = 1'b0;
      state_next                   = IdleState;
    end else if (item.last_byte) begin
      result.emit                  = 1'b1;
      result.point.code_point      = filled_value;
      result.point.sequence_length = acc_length;
      result.point.last_point      = 1'b1;
      result.point.truncated       = 1'b1;
      state_next                   = IdleState;
    end else begin
      state_next.bytes_pending  = acc_pending;
      state_next.partial_value  = acc_value;
      state_next.pending_length = acc_length;
    end
  end

endmodule

>>> rtl/lenient_utf8_decoder.sv
// Top level of the lenient UTF-8 decoder: decoder state and the result register.
// Depends on lutf8_pkg and lutf8_step.
//
//   channel  direction  handshake                 payload
//   byte     in         byte_valid / byte_ready   byte_item  (data_byte, last_byte)
//   point    out        point_valid / point_ready point_item (code_point, sequence_length,
//                                                             last_point, truncated)
//
// Each byte is decoded in the cycle it is accepted; a resulting code point appears on
// the point channel in the following cycle, held in a single result register.
// One byte can be accepted every cycle while the result register is empty or being read.
// A stalled point channel holds byte_ready low until the waiting result is taken.
// Synchronous reset returns the decoder to the start of a string and empties the output.
`timescale 1ns / 1ps

module lenient_utf8_decoder (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  lutf8_pkg::byte_item_t  byte_item,
  output logic                   point_valid,
  input  logic                   point_ready,
  output lutf8_pkg::point_item_t point_item
);
  import lutf8_pkg::*;

  dec_state_t   dec_state;
  dec_state_t   dec_state_next;
  step_result_t step_res;
  logic         byte_take;

  assign byte_ready = !point_valid || point_ready;
  assign byte_take  = byte_valid && byte_ready;

  lutf8_step u_step (
    .cur_state  (dec_state),
    .item       (byte_item),
    .state_next (dec_state_next),
    .result     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_state   <= IdleState;
      point_valid <= 1'b0;
    end else begin
      if (byte_take) begin
        dec_state <= dec_state_next;
      end
      if (byte_take) begin
        point_valid <= step_res.emit;
      end else if (point_ready) begin
        point_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take && step_res.emit) begin
      point_item <= step_res.point;
    end
  end

endmodule

>>> rtl/lutf8_checker.sv
// Port-level checks for the lenient UTF-8 decoder, bound to its top level.
// Depends on lutf8_pkg, lenient_utf8_decoder and lenient_utf8_decoder_assert.svh.
`timescale 1ns / 1ps
`include "lenient_utf8_decoder_assert.svh"

module lutf8_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   byte_valid,
  input logic                   byte_ready,
  input lutf8_pkg::byte_item_t  byte_item,
  input logic                   point_valid,
  input logic                   point_ready,
  input lutf8_pkg::point_item_t point_item
);
  import lutf8_pkg::*;

  logic last_taken;
  logic last_shown;
  logic trunc_shown;
  logic single_shown;
  logic single_ok;

  assign last_taken   = byte_valid && byte_ready && byte_item.last_byte;
  assign last_shown   = point_valid && point_item.last_point;
  assign trunc_shown  = point_valid && point_item.truncated;
  assign single_shown = point_valid && point_item.sequence_length == Len1;
  assign single_ok    = point_item.code_point[CpWidth-1:8] == '0 && !point_item.truncated;

  `LUTF8_ASSERT_ALWAYS(a_reset_empty, rst |=> !point_valid, "result pending after reset")

  `LUTF8_ASSERT(a_point_held, point_valid && !point_ready |=> point_valid, "result dropped")

  `LUTF8_ASSERT(a_last_emits, last_taken |=> last_shown, "string end gave no final code point")

  `LUTF8_ASSERT(a_trunc_is_last, trunc_shown |-> point_item.last_point, "truncated point not final")

  `LUTF8_ASSERT(a_single_byte_range, single_shown |-> single_ok, "one-byte point out of range")

endmodule

bind lenient_utf8_decoder lutf8_checker u_lutf8_checker (.*);
